// File: rtl/rlcm_pkg.sv
// Shared constants and types of the running least common multiple block.
package rlcm_pkg;

   localparam int VALUE_BITS = 32;
   localparam int WORD_BITS_DEFAULT = 32;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GCD,
      S_DIV,
      S_MUL,
      S_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

// File: rtl/rlcm_channels.sv
// Valid/ready channel interfaces for the input words and the result words.
interface rlcm_req_if;
   import rlcm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  last;

   modport source (output valid, output value, output last, input ready);
   modport sink (input valid, input value, input last, output ready);
endinterface

interface rlcm_rsp_if;
   import rlcm_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] lcm_value;
   logic                  overflow;
   logic                  list_end;

   modport source (output valid, output lcm_value, output overflow, output list_end,
                   input ready);
   modport sink (input valid, input lcm_value, input overflow, input list_end,
                 output ready);
endinterface

// File: rtl/rlcm_alu.sv
// Shared add/subtract unit used by the gcd, divide and multiply steps.
module rlcm_alu #(
   parameter int WIDTH = rlcm_pkg::WORD_BITS_DEFAULT + 1
) (
   input  rlcm_pkg::alu_op_type op,
   input  logic [WIDTH-1:0]     x,
   input  logic [WIDTH-1:0]     y,
   output logic [WIDTH:0]       result
);
   import rlcm_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: result = {1'b0, x} + {1'b0, y};
         ALU_SUB: result = {1'b0, x} - {1'b0, y};
         default: result = {1'b0, x} + {1'b0, y};
      endcase
   end

endmodule

// File: rtl/running_lcm_with_overflow_stop_top.sv
// Top level of the running least common multiple block with sticky overflow.
//
// The req channel carries one list element per word together with a last flag.
// The rsp channel returns one word per element: the running LCM, the sticky
// overflow flag and a copy of the last flag. The running value starts at 1.
// One element is in work at a time; req ready is high only while idle.
// An element that leaves the state unchanged or overflows at once goes from
// idle straight to the done state, which loads the result register once it
// is free and returns to idle for the next element. Any other element runs a
// binary gcd, a restoring divide and a shift-add multiply, all on one shared
// add/subtract unit, and then loads the result register. A finished result
// waits in that register while the receiver stalls; the next element is still
// accepted, but its result is held until the register frees. Reset is
// synchronous and clears the running value to 1, the overflow flag and the
// result valid flag. After the last element of a list the state returns to
// its reset values.
module running_lcm_with_overflow_stop_top #(
   parameter int WORD_BITS = rlcm_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   rlcm_req_if.sink    req_ch,
   rlcm_rsp_if.source  rsp_ch
);
   import rlcm_pkg::*;

   localparam int EW = (WORD_BITS > VALUE_BITS) ? WORD_BITS : VALUE_BITS;
   localparam int KB = $clog2(WORD_BITS);
   localparam logic [KB-1:0] CNT_LAST = KB'(WORD_BITS - 1);

   state_type             state_ff, state_in;
   logic [WORD_BITS-1:0]  run_ff, run_in;
   logic                  stop_ff, stop_in;
   logic [WORD_BITS-1:0]  op_a_ff, op_a_in;
   logic [WORD_BITS-1:0]  op_b_ff, op_b_in;
   logic [WORD_BITS-1:0]  op_c_ff, op_c_in;
   logic [KB-1:0]         k_ff, k_in;
   logic [KB-1:0]         cnt_ff, cnt_in;
   logic [WORD_BITS-1:0]  v_ff, v_in;
   logic                  last_ff, last_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_BITS-1:0] rsp_lcm_ff, rsp_lcm_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_end_ff, rsp_end_in;

   alu_op_type            alu_op;
   logic [WORD_BITS:0]    alu_x;
   logic [WORD_BITS:0]    alu_y;
   logic [WORD_BITS+1:0]  alu_res;

   logic [EW-1:0]         v_ext;
   logic [EW-1:0]         run_ext;
   logic [WORD_BITS-1:0]  v_low;
   logic                  v_big;
   logic                  borrow;
   logic [WORD_BITS-1:0]  quo_next;
   logic [WORD_BITS:0]    mul_sum;
   logic [WORD_BITS-1:0]  hi_next;
   logic [WORD_BITS-1:0]  lo_next;

   rlcm_alu #(
      .WIDTH (WORD_BITS + 1)
   ) u_alu (
      .op     (alu_op),
      .x      (alu_x),
      .y      (alu_y),
      .result (alu_res)
   );

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.lcm_value = rsp_lcm_ff;
   assign rsp_ch.overflow  = rsp_ovf_ff;
   assign rsp_ch.list_end  = rsp_end_ff;

   assign v_ext    = EW'(req_ch.value);
   assign run_ext  = EW'(run_ff);
   assign v_low    = v_ext[WORD_BITS-1:0];
   assign v_big    = (v_ext >> WORD_BITS) != '0;
   assign borrow   = alu_res[WORD_BITS+1];
   assign quo_next = {op_c_ff[WORD_BITS-2:0], ~borrow};
   assign mul_sum  = alu_res[WORD_BITS:0];
   assign hi_next  = mul_sum[WORD_BITS:1];
   assign lo_next  = {mul_sum[0], op_c_ff[WORD_BITS-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         run_ff       <= WORD_BITS'(1);
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_ff       <= run_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_a_ff    <= op_a_in;
      op_b_ff    <= op_b_in;
      op_c_ff    <= op_c_in;
      k_ff       <= k_in;
      cnt_ff     <= cnt_in;
      v_ff       <= v_in;
      last_ff    <= last_in;
      rsp_lcm_ff <= rsp_lcm_in;
      rsp_ovf_ff <= rsp_ovf_in;
      rsp_end_ff <= rsp_end_in;
   end

   always_comb begin
      state_in     = state_ff;
      run_in       = run_ff;
      stop_in      = stop_ff;
      op_a_in      = op_a_ff;
      op_b_in      = op_b_ff;
      op_c_in      = op_c_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      v_in         = v_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_lcm_in   = rsp_lcm_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_end_in   = rsp_end_ff;
      alu_op       = ALU_ADD;
      alu_x        = '0;
      alu_y        = '0;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               v_in    = v_low;
               last_in = req_ch.last;
               if (stop_ff || (v_ext == run_ext)) begin
                  state_in = S_DONE;
               end else if ((v_ext == '0) || v_big || (&v_low)) begin
                  stop_in  = 1'b1;
                  state_in = S_DONE;
               end else begin
                  op_a_in  = run_ff;
                  op_b_in  = v_low;
                  k_in     = '0;
                  state_in = S_GCD;
               end
            end
         end
         S_GCD: begin
            alu_op = ALU_SUB;
            alu_x  = {1'b0, op_a_ff};
            alu_y  = {1'b0, op_b_ff};
            if (op_a_ff == op_b_ff) begin
               op_b_in  = op_a_ff << k_ff;
               op_a_in  = '0;
               op_c_in  = run_ff;
               cnt_in   = CNT_LAST;
               state_in = S_DIV;
            end else if (!op_a_ff[0] && !op_b_ff[0]) begin
               op_a_in = op_a_ff >> 1;
               op_b_in = op_b_ff >> 1;
               k_in    = k_ff + KB'(1);
            end else if (!op_a_ff[0]) begin
               op_a_in = op_a_ff >> 1;
            end else if (!op_b_ff[0]) begin
               op_b_in = op_b_ff >> 1;
            end else if (borrow) begin
               op_a_in = op_b_ff;
               op_b_in = op_a_ff;
            end else begin
               op_a_in = alu_res[WORD_BITS:1];
            end
         end
         S_DIV: begin
            alu_op  = ALU_SUB;
            alu_x   = {op_a_ff, op_c_ff[WORD_BITS-1]};
            alu_y   = {1'b0, op_b_ff};
            op_a_in = borrow ? alu_x[WORD_BITS-1:0] : alu_res[WORD_BITS-1:0];
            if (cnt_ff == '0) begin
               op_b_in  = quo_next;
               op_a_in  = '0;
               op_c_in  = v_ff;
               cnt_in   = CNT_LAST;
               state_in = S_MUL;
            end else begin
               op_c_in = quo_next;
               cnt_in  = cnt_ff - KB'(1);
            end
         end
         S_MUL: begin
            alu_op = ALU_ADD;
            alu_x  = {1'b0, op_a_ff};
            alu_y  = op_c_ff[0] ? {1'b0, op_b_ff} : '0;
            if (cnt_ff == '0) begin
               if ((hi_next != '0) || (&lo_next)) begin
                  stop_in = 1'b1;
               end else begin
                  run_in = lo_next;
               end
               state_in = S_DONE;
            end else begin
               op_a_in = hi_next;
               op_c_in = lo_next;
               cnt_in  = cnt_ff - KB'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_lcm_in   = VALUE_BITS'(run_ff);
               rsp_ovf_in   = stop_ff;
               rsp_end_in   = last_ff;
               if (last_ff) begin
                  run_in  = WORD_BITS'(1);
                  stop_in = 1'b0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_run_nonzero: assert property (@(posedge clock) disable iff (reset)
      run_ff != '0)
      else $error("Running LCM became zero.");

   a_gcd_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GCD) |-> ((op_a_ff != '0) && (op_b_ff != '0)))
      else $error("Gcd operand reached zero.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready) |=> (state_ff != S_IDLE))
      else $error("Accepted word did not start work.");

   a_run_below_max: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && !stop_ff) |-> !(&run_ff))
      else $error("Running LCM reached full scale without overflow.");

endmodule

// File: tb/running_lcm_with_overflow_stop_top_tb.sv
// Testbench for the running LCM block: directed lists, random lists and a self-checking predictor.
`timescale 1ns / 1ps

module running_lcm_with_overflow_stop_top_tb;
   import rlcm_pkg::*;

   localparam int WORD_BITS = WORD_BITS_DEFAULT;
   localparam logic [63:0] MAX_WORD = (64'd1 << WORD_BITS) - 64'd1;
   localparam int TOTAL_WORDS = 1200;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [VALUE_BITS-1:0] lcm_value;
      logic                  overflow;
      logic                  list_end;
   } lcm_result_type;

   logic clock;
   logic reset;

   rlcm_req_if req_ch ();
   rlcm_rsp_if rsp_ch ();

   running_lcm_with_overflow_stop_top #(
      .WORD_BITS(WORD_BITS)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   logic [VALUE_BITS-1:0] lcm_running;
   logic                  lcm_stopped;
   lcm_result_type        lcm_expected[$];
   lcm_result_type        lcm_due;
   logic                  steady_flow;
   int                    words_sent;
   int                    lists_sent;
   int                    results_checked;
   int                    overflow_results;
   int                    mismatches;
   int                    idle_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic lcm_result_type predict_lcm(input logic [VALUE_BITS-1:0] v, input logic l);
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] t;
      logic [63:0] n;
      lcm_result_type r;
      if (!lcm_stopped && v != lcm_running) begin
         if (v == '0 || 64'(v) >= MAX_WORD) begin
            lcm_stopped = 1'b1;
         end else begin
            a = 64'(lcm_running);
            b = 64'(v);
            while (b != 64'd0) begin
               t = a % b;
               a = b;
               b = t;
            end
            n = (64'(lcm_running) / a) * 64'(v);
            if (n >= MAX_WORD) begin
               lcm_stopped = 1'b1;
            end else begin
               lcm_running = n[VALUE_BITS-1:0];
            end
         end
      end
      r.lcm_value = lcm_running;
      r.overflow = lcm_stopped;
      r.list_end = l;
      if (l) begin
         lcm_running = 1;
         lcm_stopped = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [VALUE_BITS-1:0] pick_element();
      int sel;
      logic [63:0] p;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         return VALUE_BITS'($urandom_range(1, 64));
      end else if (sel < 45) begin
         return VALUE_BITS'($urandom_range(1, 1000));
      end else if (sel < 55) begin
         return lcm_running;
      end else if (sel < 65) begin
         p = 64'(lcm_running) * 64'($urandom_range(2, 7));
         return p[VALUE_BITS-1:0];
      end else if (sel < 75) begin
         return VALUE_BITS'($urandom);
      end else if (sel < 80) begin
         return '0;
      end else if (sel < 85) begin
         return '1;
      end else if (sel < 90) begin
         return {{(VALUE_BITS-1){1'b1}}, 1'b0};
      end else begin
         return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
      end
   endfunction

   task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic l);
      if (!steady_flow && $urandom_range(0, 99) < 25) begin
         req_ch.valid <= 1'b0;
         if ($urandom_range(0, 99) < 70) begin
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end else begin
            repeat ($urandom_range(1, 180)) @(posedge clock);
         end
      end
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      req_ch.last <= l;
      do @(posedge clock); while (!req_ch.ready);
      lcm_expected.push_back(predict_lcm(v, l));
      words_sent++;
      if (l) begin
         lists_sent++;
      end
   endtask

   task automatic send_list(input logic [VALUE_BITS-1:0] vals[$]);
      foreach (vals[i]) begin
         send_word(vals[i], i == vals.size() - 1);
      end
   endtask

   task automatic wait_drained();
      while (lcm_expected.size() != 0) @(posedge clock);
   endtask

   task automatic test_basic_list();
      send_list('{32'd1, 32'd2, 32'd3, 32'd4, 32'd12, 32'd5});
   endtask

   task automatic test_special_cases();
      send_list('{32'd0, 32'd7});
      send_list('{32'd6, 32'hFFFF_FFFF, 32'd6});
      send_list('{32'h0001_0000, 32'h0001_0001, 32'd2});
      send_list('{32'd3, 32'd5, 32'd17, 32'd257, 32'd65537});
      send_list('{32'hFFFF_FFFE});
   endtask

   task automatic send_random_lists(input int count);
      int len;
      int stop_at;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         len = $urandom_range(1, 10);
         for (int i = 0; i < len; i++) begin
            send_word(pick_element(), i == len - 1);
         end
      end
   endtask

   task automatic test_drain_pause();
      send_random_lists(20);
      req_ch.valid <= 1'b0;
      wait_drained();
      send_random_lists(20);
   endtask

   task automatic test_back_to_back();
      steady_flow = 1'b1;
      send_random_lists(150);
      steady_flow = 1'b0;
   endtask

   task automatic test_random_lists();
      if (words_sent < TOTAL_WORDS) begin
         send_random_lists(TOTAL_WORDS - words_sent);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (lcm_expected.size() == 0) begin
               $error("unexpected result word: lcm_value %0d, overflow %0b, list_end %0b",
                      rsp_ch.lcm_value, rsp_ch.overflow, rsp_ch.list_end);
               mismatches++;
            end else begin
               lcm_due = lcm_expected.pop_front();
               if (rsp_ch.lcm_value !== lcm_due.lcm_value) begin
                  $error("lcm_value: expected %0d, got %0d", lcm_due.lcm_value, rsp_ch.lcm_value);
                  mismatches++;
               end
               if (rsp_ch.overflow !== lcm_due.overflow) begin
                  $error("overflow: expected %0b, got %0b", lcm_due.overflow, rsp_ch.overflow);
                  mismatches++;
               end
               if (rsp_ch.list_end !== lcm_due.list_end) begin
                  $error("list_end: expected %0b, got %0b", lcm_due.list_end, rsp_ch.list_end);
                  mismatches++;
               end
               results_checked++;
               if (lcm_due.overflow) begin
                  overflow_results++;
               end
            end
         end
         rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 25);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no word moved for %0d cycles, %0d results outstanding.",
                  idle_cycles, lcm_expected.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset = 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.value <= '0;
      req_ch.last <= 1'b0;
      lcm_running = 1;
      lcm_stopped = 1'b0;
      steady_flow = 1'b0;
      words_sent = 0;
      lists_sent = 0;
      results_checked = 0;
      overflow_results = 0;
      mismatches = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_list();
      test_special_cases();
      test_drain_pause();
      test_back_to_back();
      test_random_lists();

      req_ch.valid <= 1'b0;
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d words in %0d lists, directed special cases and random lists.",
               words_sent, lists_sent);
      $display("Checked %0d result words, %0d of them with overflow set.",
               results_checked, overflow_results);
      if (mismatches == 0 && lcm_expected.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
